### hw/rtl/ckd_pkg.sv
package ckd_pkg;

  // Payload chunk length in bytes and the width of a counter that can hold it.
  localparam int unsigned CHUNK_BYTES = 32;
  localparam int unsigned CHUNK_W     = $clog2(CHUNK_BYTES + 1);

  localparam logic [31:0] SIZE_XOR   = 32'hC92E568B;
  localparam logic [31:0] KEY_ADD    = 32'hA3B376C9;
  localparam logic [31:0] SEED_RESET = 32'hB29D5A0C;

  // Two separator bytes follow every chunk.
  localparam logic [1:0] SEP_BYTES = 2'd2;

  // The header ends on its eighth byte.
  localparam logic [2:0] HDR_LAST = 3'd7;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_SEP     = 2'd2
  } phase_t;

  // Result of one accepted word, handed from the core to the output register.
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } result_t;

  function automatic logic [31:0] next_key(input logic [31:0] k);
    logic [31:0] t;
    t = {k[30:0], 1'b0} + {31'd0, k[15]} + KEY_ADD;
    return ~t;
  endfunction

endpackage

### hw/rtl/ckd_core.sv
module ckd_core
  import ckd_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [7:0]    in_byte,
  input  logic          cfg_we,
  input  logic [31:0]   cfg_wdata,
  output result_t       result
);

  phase_t               phase, phase_next;
  logic [2:0]           header_count, header_count_next;
  logic [31:0]          size_shift, size_shift_next;
  logic [31:0]          bytes_remaining, bytes_remaining_next;
  logic [CHUNK_W-1:0]   chunk_left, chunk_left_next;
  logic [1:0]           skip_left, skip_left_next;
  logic [31:0]          key_reg, key_reg_next;
  logic [31:0]          key_seed;

  logic [31:0]          rem_dec;
  logic [CHUNK_W-1:0]   chunk_dec;
  logic [1:0]           skip_dec;
  logic [31:0]          size_val;
  logic [CHUNK_W-1:0]   first_len;

  assign rem_dec   = bytes_remaining - 32'd1;
  assign chunk_dec = chunk_left - CHUNK_W'(1);
  assign skip_dec  = (skip_left != 2'd0) ? skip_left - 2'd1 : 2'd0;
  assign size_val  = (~size_shift_next) ^ SIZE_XOR;

  always_comb begin
    if ((size_val % CHUNK_BYTES) == 32'd0) begin
      first_len = CHUNK_W'(CHUNK_BYTES);
    end else begin
      first_len = CHUNK_W'(size_val % CHUNK_BYTES);
    end
  end

  // Next state for one accepted byte.
  always_comb begin
    phase_next           = phase;
    header_count_next    = header_count;
    size_shift_next      = size_shift;
    bytes_remaining_next = bytes_remaining;
    chunk_left_next      = chunk_left;
    skip_left_next       = skip_left;
    key_reg_next         = key_reg;
    case (phase)
      PH_PAYLOAD: begin
        key_reg_next         = next_key(key_reg);
        bytes_remaining_next = rem_dec;
        chunk_left_next      = chunk_dec;
        if (chunk_dec == '0 || rem_dec == 32'd0) begin
          chunk_left_next = '0;
          skip_left_next  = SEP_BYTES;
          phase_next      = PH_SEP;
        end
      end
      PH_SEP: begin
        skip_left_next = skip_dec;
        if (skip_dec == 2'd0) begin
          if (bytes_remaining == 32'd0) begin
            phase_next        = PH_HEADER;
            header_count_next = '0;
          end else begin
            chunk_left_next = CHUNK_W'(CHUNK_BYTES);
            phase_next      = PH_PAYLOAD;
          end
        end
      end
      default: begin
        phase_next = PH_HEADER;
        case (header_count)
          3'd0:    size_shift_next = {24'd0, in_byte};
          3'd1:    size_shift_next[15:8]  = in_byte;
          3'd2:    size_shift_next[23:16] = in_byte;
          3'd3:    size_shift_next[31:24] = in_byte;
          default: size_shift_next = size_shift;
        endcase
        if (header_count == HDR_LAST) begin
          header_count_next = '0;
          if (size_val != 32'd0) begin
            bytes_remaining_next = size_val;
            chunk_left_next      = first_len;
            key_reg_next         = key_seed;
            phase_next           = PH_PAYLOAD;
          end
        end else begin
          header_count_next = header_count + 3'd1;
        end
      end
    endcase
  end

  // Payload bytes yield a result; header and separator bytes yield none.
  always_comb begin
    result.valid = accept && (phase == PH_PAYLOAD);
    result.data  = in_byte ^ key_reg[7:0];
    result.last  = (rem_dec == 32'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HEADER;
      header_count    <= '0;
      size_shift      <= '0;
      bytes_remaining <= '0;
      chunk_left      <= '0;
      skip_left       <= '0;
      key_reg         <= SEED_RESET;
    end else if (accept) begin
      phase           <= phase_next;
      header_count    <= header_count_next;
      size_shift      <= size_shift_next;
      bytes_remaining <= bytes_remaining_next;
      chunk_left      <= chunk_left_next;
      skip_left       <= skip_left_next;
      key_reg         <= key_reg_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_seed <= SEED_RESET;
    end else if (cfg_we) begin
      key_seed <= cfg_wdata;
    end
  end

endmodule

### hw/rtl/ckd_out_reg.sv
module ckd_out_reg
  import ckd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  result_t    result,
  output logic       can_load,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       last
);

  // The register can take a new word when it is empty or is being emptied.
  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= result.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && result.valid) begin
      out_byte <= result.data;
      last     <= result.last;
    end
  end

endmodule

### hw/rtl/chunked_keystream_byte_decryptor.sv
// Chunked keystream byte decryptor.
// The input channel (in_valid, in_ready, in_byte) takes the raw file one byte
// word at a time: an eight-byte header, then the payload in chunks, each chunk
// followed by two separator bytes. The output channel (out_valid, out_ready,
// out_byte, last) carries one decrypted word per payload byte, with last set
// on the final payload byte of the file. Header and separator bytes produce
// no output word.
// A payload byte is decrypted combinationally and registered in the output
// register when accepted. Throughput is one word per cycle without stalls,
// set by the single output register; the key update is shift, add, invert.
// The key seed is written through cfg_we and cfg_wdata and takes effect at
// the next header. Reset clears the parser to the header phase, empties the
// output register and restores the default seed.
// When the receiver stalls with a word held in the output register, in_ready
// drops, so no further bytes are taken until that word leaves.
module chunked_keystream_byte_decryptor
  import ckd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        last,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  result_t result;
  logic    can_load;
  logic    accept;

  // Every byte is taken in step with the output register, so a header or
  // separator byte also waits while a stalled word sits there.
  assign in_ready = can_load;
  assign accept   = in_valid && in_ready;

  ckd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_byte   (in_byte),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .result    (result)
  );

  ckd_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .result    (result),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .last      (last)
  );

endmodule

### hw/rtl/ckd_checker.sv
module ckd_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       last
);

  // A held output word keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last))
    else $error("output word changed while stalled");

  // An empty output register never blocks the input.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output register");

  // A new output word only appears after an input byte was taken.
  a_out_from_input: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("output word without an accepted input byte");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind chunked_keystream_byte_decryptor ckd_checker u_ckd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_byte  (out_byte),
  .last      (last)
);
